[hdl/c3ms_pkg.sv]
// Shared types and constants for the streaming 3x3 convolution unit.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package c3ms_pkg;

   localparam int DATA_BITS     = 8;
   localparam int ACC_BITS      = 32;
   localparam int PROD_BITS     = 2 * DATA_BITS;
   localparam int DOT_BITS      = PROD_BITS + 4;
   localparam int TAPS          = 9;
   localparam int OCH_BITS      = 4;
   localparam int RESULT_LIMIT  = 16;
   localparam int KIND_BITS     = 2;
   localparam int CSR_BITS      = 2;
   localparam int CSR_DATA_BITS = 16;

   // Item kinds
   localparam logic [KIND_BITS-1:0] KIND_ACT    = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_WEIGHT = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_BIAS   = 2'd2;

   // Register indexes
   localparam logic [CSR_BITS-1:0] CSR_IN_CNT  = 2'd0;
   localparam logic [CSR_BITS-1:0] CSR_OUT_CNT = 2'd1;
   localparam logic [CSR_BITS-1:0] CSR_ROWS    = 2'd2;
   localparam logic [CSR_BITS-1:0] CSR_COLS    = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic                take;
      logic                update;
      logic                issue;
      logic                emit;
      logic                emit_last;
      logic [OCH_BITS-1:0] idx;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic                is_act;
      logic                emit_pix;
      logic                rsp_free;
      logic [OCH_BITS-1:0] n_out_m1;
   } status_type;

endpackage

`default_nettype wire

[hdl/c3ms_if.sv]
// Valid/ready channel interfaces for request and response transactions.
// Depends on c3ms_pkg for field widths.
`default_nettype none

interface c3ms_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [c3ms_pkg::KIND_BITS-1:0]        kind;
   logic signed [c3ms_pkg::DATA_BITS-1:0] activation;
   logic [c3ms_pkg::OCH_BITS-1:0]         load_out_channel;
   logic [c3ms_pkg::OCH_BITS-1:0]         load_in_channel;
   logic [3:0]                            load_tap;
   logic signed [c3ms_pkg::DATA_BITS-1:0] weight_value;
   logic signed [c3ms_pkg::ACC_BITS-1:0]  bias_value;

   modport source (output valid, kind, activation, load_out_channel, load_in_channel,
                   load_tap, weight_value, bias_value, input ready);
   modport sink (input valid, kind, activation, load_out_channel, load_in_channel,
                 load_tap, weight_value, bias_value, output ready);
endinterface

interface c3ms_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [c3ms_pkg::ACC_BITS-1:0] sum;
   logic [c3ms_pkg::OCH_BITS-1:0]        out_channel;
   logic                                 last;

   modport source (output valid, sum, out_channel, last, input ready);
   modport sink (input valid, sum, out_channel, last, output ready);
endinterface

`default_nettype wire

[hdl/conv3x3_multichannel_stream_unit.sv]
// Top level of the line-buffered 3x3 multichannel convolution unit.
// Depends on c3ms_pkg, c3ms_if, c3ms_ctrl and c3ms_dp.
//
//   channel   dir  handshake       payload
//   req_chan  in   valid/ready     kind, activation, load fields, weight, bias
//   rsp_chan  out  valid/ready     sum, out_channel, last
//   csr_*     in   csr_wr_en only  csr_index, csr_wdata (16 bits)
//
// Weight and bias loads are taken in the idle state. An activation runs a window
// update, one MAC issue per output channel through a 4-stage
// multiply/sum/accumulate pipe, and its drain. A pixel that emits then
// sends one sum per output channel on the response register, one sum per
// cycle while rsp_chan.ready lets the register drain, and stalls otherwise.
// Synchronous reset; no clearing pass, the unit accepts right after reset.
`default_nettype none

module conv3x3_multichannel_stream_unit #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int LINE_WIDTH       = 1024
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   c3ms_req_if.sink                                req_chan,
   c3ms_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_wr_en,
   input  wire logic [c3ms_pkg::CSR_BITS-1:0]      csr_index,
   input  wire logic [c3ms_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   c3ms_pkg::cmd_type    cmd;
   c3ms_pkg::status_type st;

   c3ms_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .st        (st),
      .cmd       (cmd)
   );

   c3ms_dp #(
      .MAX_IN_CHANNELS  (MAX_IN_CHANNELS),
      .MAX_OUT_CHANNELS (MAX_OUT_CHANNELS),
      .LINE_WIDTH       (LINE_WIDTH)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_wr_en            (csr_wr_en),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_kind             (req_chan.kind),
      .req_activation       (req_chan.activation),
      .req_load_out_channel (req_chan.load_out_channel),
      .req_load_in_channel  (req_chan.load_in_channel),
      .req_load_tap         (req_chan.load_tap),
      .req_weight_value     (req_chan.weight_value),
      .req_bias_value       (req_chan.bias_value),
      .cmd                  (cmd),
      .st                   (st),
      .rsp_ready            (rsp_chan.ready),
      .rsp_valid            (rsp_chan.valid),
      .rsp_sum              (rsp_chan.sum),
      .rsp_out_channel      (rsp_chan.out_channel),
      .rsp_last             (rsp_chan.last)
   );

endmodule

`default_nettype wire

[hdl/c3ms_dp.sv]
// Datapath: config registers, line/window/weight memories, MAC pipeline,
// accumulators and the response register. Depends on c3ms_pkg.
`default_nettype none

module c3ms_dp #(
   parameter int MAX_IN_CHANNELS  = 16,
   parameter int MAX_OUT_CHANNELS = 16,
   parameter int LINE_WIDTH       = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [c3ms_pkg::CSR_BITS-1:0]         csr_index,
   input  wire logic [c3ms_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic [c3ms_pkg::KIND_BITS-1:0]        req_kind,
   input  wire logic signed [c3ms_pkg::DATA_BITS-1:0] req_activation,
   input  wire logic [c3ms_pkg::OCH_BITS-1:0]         req_load_out_channel,
   input  wire logic [c3ms_pkg::OCH_BITS-1:0]         req_load_in_channel,
   input  wire logic [3:0]                            req_load_tap,
   input  wire logic signed [c3ms_pkg::DATA_BITS-1:0] req_weight_value,
   input  wire logic signed [c3ms_pkg::ACC_BITS-1:0]  req_bias_value,
   input  wire c3ms_pkg::cmd_type                     cmd,
   output c3ms_pkg::status_type                       st,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic signed [c3ms_pkg::ACC_BITS-1:0]       rsp_sum,
   output logic [c3ms_pkg::OCH_BITS-1:0]              rsp_out_channel,
   output logic                                       rsp_last
);

   localparam int DB    = c3ms_pkg::DATA_BITS;
   localparam int AB    = c3ms_pkg::ACC_BITS;
   localparam int PB    = c3ms_pkg::PROD_BITS;
   localparam int TAPS  = c3ms_pkg::TAPS;
   localparam int ICW   = (MAX_IN_CHANNELS > 1) ? $clog2(MAX_IN_CHANNELS) : 1;
   localparam int OSW   = (MAX_OUT_CHANNELS > 1) ? $clog2(MAX_OUT_CHANNELS) : 1;
   localparam int COLW  = $clog2(LINE_WIDTH);
   localparam int OLIM  = (MAX_OUT_CHANNELS < c3ms_pkg::RESULT_LIMIT) ?
                          MAX_OUT_CHANNELS : c3ms_pkg::RESULT_LIMIT;
   localparam int CNTW  = ($clog2(MAX_IN_CHANNELS + 1) > 5) ? $clog2(MAX_IN_CHANNELS + 1) : 5;
   localparam int COLCW = ($clog2(LINE_WIDTH + 1) > 11) ? $clog2(LINE_WIDTH + 1) : 11;
   localparam int LAW   = ICW + COLW;
   localparam int WAW   = OSW + ICW;

   // Config registers
   logic [4:0]  in_cnt_ff, out_cnt_ff;
   logic [15:0] rows_ff;
   logic [10:0] cols_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= 5'd1;
         out_cnt_ff <= 5'd1;
         rows_ff    <= 16'd3;
         cols_ff    <= 11'd3;
      end else if (csr_wr_en) begin
         case (csr_index)
            c3ms_pkg::CSR_IN_CNT:  in_cnt_ff  <= csr_wdata[4:0];
            c3ms_pkg::CSR_OUT_CNT: out_cnt_ff <= csr_wdata[4:0];
            c3ms_pkg::CSR_ROWS:    rows_ff    <= csr_wdata;
            c3ms_pkg::CSR_COLS:    cols_ff    <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // Clamped counts and positions
   logic [ICW-1:0]   chan_pos_ff, ch_c;
   logic [COLW-1:0]  col_pos_ff, col_c;
   logic [15:0]      row_pos_ff, row_c, n_rows;
   logic [CNTW-1:0]  n_in, in_ext;
   logic [4:0]       n_out;
   logic [COLCW-1:0] n_cols, cols_ext;
   logic             last_chan, col_end, row_end, valid_c;

   always_comb begin
      in_ext   = CNTW'(in_cnt_ff);
      cols_ext = COLCW'(cols_ff);
      n_in     = (in_cnt_ff == 5'd0) ? CNTW'(1) :
                 (in_ext > CNTW'(MAX_IN_CHANNELS)) ? CNTW'(MAX_IN_CHANNELS) : in_ext;
      n_out    = (out_cnt_ff == 5'd0) ? 5'd1 :
                 (out_cnt_ff > 5'(OLIM)) ? 5'(OLIM) : out_cnt_ff;
      n_rows   = (rows_ff == 16'd0) ? 16'd1 : rows_ff;
      n_cols   = (cols_ff == 11'd0) ? COLCW'(1) :
                 (cols_ext > COLCW'(LINE_WIDTH)) ? COLCW'(LINE_WIDTH) : cols_ext;
      ch_c     = (CNTW'(chan_pos_ff) >= n_in) ? ICW'(n_in - CNTW'(1)) : chan_pos_ff;
      col_c    = (COLCW'(col_pos_ff) >= n_cols) ? COLW'(n_cols - COLCW'(1)) : col_pos_ff;
      row_c    = (row_pos_ff >= n_rows) ? (n_rows - 16'd1) : row_pos_ff;
      last_chan = (CNTW'(ch_c) + CNTW'(1)) >= n_in;
      col_end   = (COLCW'(col_c) + COLCW'(1)) >= n_cols;
      row_end   = ({1'b0, row_c} + 17'd1) >= {1'b0, n_rows};
      valid_c   = (row_c >= 16'd2) && (COLCW'(col_c) >= COLCW'(2));
   end

   logic take_act, take_wt, take_bias;
   assign take_act  = cmd.take && (req_kind == c3ms_pkg::KIND_ACT);
   assign take_wt   = cmd.take && (req_kind == c3ms_pkg::KIND_WEIGHT);
   assign take_bias = cmd.take && (req_kind == c3ms_pkg::KIND_BIAS);

   // Position counters and per-item control flags
   logic            emit_pix_ff, frame_end_ff, ch0_ff, valid_ff;
   logic [3:0]      n_out_m1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_pos_ff  <= '0;
         col_pos_ff   <= '0;
         row_pos_ff   <= '0;
         emit_pix_ff  <= 1'b0;
         frame_end_ff <= 1'b0;
         ch0_ff       <= 1'b0;
         valid_ff     <= 1'b0;
         n_out_m1_ff  <= '0;
      end else if (take_act) begin
         emit_pix_ff  <= valid_c && last_chan;
         frame_end_ff <= last_chan && col_end && row_end;
         ch0_ff       <= (ch_c == '0);
         valid_ff     <= valid_c;
         n_out_m1_ff  <= 4'(n_out - 5'd1);
         col_pos_ff   <= col_c;
         row_pos_ff   <= row_c;
         if (!last_chan) begin
            chan_pos_ff <= ch_c + ICW'(1);
         end else begin
            chan_pos_ff <= '0;
            if (!col_end) begin
               col_pos_ff <= col_c + COLW'(1);
            end else begin
               col_pos_ff <= '0;
               row_pos_ff <= row_end ? 16'd0 : (row_c + 16'd1);
            end
         end
      end
   end

   // Line store: two previous rows per channel and column
   logic [2*DB-1:0] lmem [2**LAW];
   logic [2*DB-1:0] lrd_ff;
   logic [LAW-1:0]  la_ff;
   logic [ICW-1:0]  ch_ff;
   logic [DB-1:0]   act_ff;

   // Window store: 3x3 neighborhood per channel, valid bits clear at frame end
   logic [TAPS*DB-1:0]         winmem [MAX_IN_CHANNELS];
   logic [TAPS*DB-1:0]         win_rd_ff, win_ff, win_old, win_new;
   logic [MAX_IN_CHANNELS-1:0] wv_ff;
   logic                       win_ok_ff;

   always_ff @(posedge clock) begin
      if (take_act) begin
         lrd_ff    <= lmem[{ch_c, col_c}];
         la_ff     <= {ch_c, col_c};
         ch_ff     <= ch_c;
         act_ff    <= req_activation;
         win_rd_ff <= winmem[ch_c];
         win_ok_ff <= wv_ff[ch_c];
      end
      if (cmd.update) begin
         lmem[la_ff]   <= {act_ff, lrd_ff[2*DB-1:DB]};
         winmem[ch_ff] <= win_new;
         win_ff        <= win_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff <= '0;
      end else if (cmd.update) begin
         if (frame_end_ff) wv_ff <= '0;
         else              wv_ff[ch_ff] <= 1'b1;
      end
   end

   // Shift each window row left by one and append the new column
   always_comb begin
      win_old = win_ok_ff ? win_rd_ff : '0;
      win_new = '0;
      for (int r = 0; r < 3; r++) begin
         win_new[(r*3)*DB +: DB]   = win_old[(r*3+1)*DB +: DB];
         win_new[(r*3+1)*DB +: DB] = win_old[(r*3+2)*DB +: DB];
      end
      win_new[2*DB +: DB] = lrd_ff[DB-1:0];
      win_new[5*DB +: DB] = lrd_ff[2*DB-1:DB];
      win_new[8*DB +: DB] = act_ff;
   end

   // Weight and bias stores
   logic [DB-1:0] wmem [2**WAW][TAPS];
   logic [AB-1:0] bias_mem [MAX_OUT_CHANNELS];

   always_ff @(posedge clock) begin
      if (take_wt && ({28'd0, req_load_out_channel} < 32'(MAX_OUT_CHANNELS)) &&
          ({28'd0, req_load_in_channel} < 32'(MAX_IN_CHANNELS)) &&
          (req_load_tap < 4'(TAPS))) begin
         wmem[{OSW'(req_load_out_channel), ICW'(req_load_in_channel)}][req_load_tap]
            <= req_weight_value;
      end
      if (take_bias && ({28'd0, req_load_out_channel} < 32'(MAX_OUT_CHANNELS))) begin
         bias_mem[OSW'(req_load_out_channel)] <= req_bias_value;
      end
   end

   // MAC pipeline: weight fetch, products, dot sum, accumulate
   logic [DB-1:0]        wrow_ff [TAPS];
   logic signed [PB-1:0] prod_ff [TAPS];
   logic signed [c3ms_pkg::DOT_BITS-1:0] dot_ff, dot_sum;
   logic [AB-1:0]        bias_s1_ff, bias_s2_ff, bias_s3_ff, acc_rd_ff, acc_base;
   logic [OSW-1:0]       o_s1_ff, o_s2_ff, o_s3_ff;
   logic                 s1_ff, s2_ff, s3_ff, acc_ok_rd_ff;
   logic [AB-1:0]        acc_mem [MAX_OUT_CHANNELS];
   logic [MAX_OUT_CHANNELS-1:0] acc_ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff <= 1'b0;
         s2_ff <= 1'b0;
         s3_ff <= 1'b0;
      end else begin
         s1_ff <= cmd.issue;
         s2_ff <= s1_ff;
         s3_ff <= s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         wrow_ff    <= wmem[{OSW'(cmd.idx), ch_ff}];
         bias_s1_ff <= bias_mem[OSW'(cmd.idx)];
         o_s1_ff    <= OSW'(cmd.idx);
      end
      for (int t = 0; t < TAPS; t++) begin
         prod_ff[t] <= $signed(win_ff[t*DB +: DB]) * $signed(wrow_ff[t]);
      end
      bias_s2_ff   <= bias_s1_ff;
      o_s2_ff      <= o_s1_ff;
      dot_ff       <= dot_sum;
      acc_rd_ff    <= acc_mem[o_s2_ff];
      acc_ok_rd_ff <= acc_ok_ff[o_s2_ff];
      bias_s3_ff   <= bias_s2_ff;
      o_s3_ff      <= o_s2_ff;
      if (s3_ff) begin
         acc_mem[o_s3_ff] <= acc_base + (valid_ff ? AB'(dot_ff) : '0);
      end
   end

   always_comb begin
      dot_sum = '0;
      for (int t = 0; t < TAPS; t++) begin
         dot_sum = dot_sum + c3ms_pkg::DOT_BITS'(prod_ff[t]);
      end
      acc_base = ch0_ff ? bias_s3_ff : (acc_ok_rd_ff ? acc_rd_ff : '0);
   end

   always_ff @(posedge clock) begin
      if (reset)      acc_ok_ff <= '0;
      else if (s3_ff) acc_ok_ff[o_s3_ff] <= 1'b1;
   end

   // Response register
   logic          rsp_v_ff, rsp_last_ff;
   logic [AB-1:0] rsp_sum_ff;
   logic [3:0]    rsp_ch_ff;

   always_ff @(posedge clock) begin
      if (reset)               rsp_v_ff <= 1'b0;
      else if (cmd.emit)       rsp_v_ff <= 1'b1;
      else if (rsp_ready)      rsp_v_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sum_ff  <= acc_mem[OSW'(cmd.idx)];
         rsp_ch_ff   <= cmd.idx;
         rsp_last_ff <= cmd.emit_last;
      end
   end

   assign rsp_valid       = rsp_v_ff;
   assign rsp_sum         = rsp_sum_ff;
   assign rsp_out_channel = rsp_ch_ff;
   assign rsp_last        = rsp_last_ff;

   assign st.is_act   = (req_kind == c3ms_pkg::KIND_ACT);
   assign st.emit_pix = emit_pix_ff;
   assign st.rsp_free = !rsp_v_ff || rsp_ready;
   assign st.n_out_m1 = n_out_m1_ff;

endmodule

`default_nettype wire

[hdl/c3ms_ctrl.sv]
// Controller: sequences window update, MAC issue, pipeline drain and emission.
// Depends on c3ms_pkg command and status structs.
`default_nettype none

module c3ms_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire c3ms_pkg::status_type st,
   output c3ms_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_UPDATE, S_ACCUM, S_DRAIN, S_EMIT
   } state_type;

   localparam logic [1:0] DRAIN_LAST = 2'd2;

   state_type                     state_ff;
   logic [c3ms_pkg::OCH_BITS-1:0] idx_ff;
   logic [1:0]                    drain_ff;

   // Commands
   always_comb begin
      cmd.take      = req_valid && (state_ff == S_IDLE);
      cmd.update    = (state_ff == S_UPDATE);
      cmd.issue     = (state_ff == S_ACCUM);
      cmd.emit      = (state_ff == S_EMIT) && st.rsp_free;
      cmd.emit_last = (idx_ff == st.n_out_m1);
      cmd.idx       = idx_ff;
   end

   assign req_ready = (state_ff == S_IDLE);

   // State machine
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         drain_ff <= '0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (cmd.take && st.is_act) state_ff <= S_UPDATE;
            end
            S_UPDATE: begin
               idx_ff   <= '0;
               state_ff <= S_ACCUM;
            end
            S_ACCUM: begin
               if (idx_ff == st.n_out_m1) begin
                  drain_ff <= '0;
                  state_ff <= S_DRAIN;
               end else begin
                  idx_ff <= idx_ff + 1'b1;
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == DRAIN_LAST) begin
                  idx_ff   <= '0;
                  state_ff <= st.emit_pix ? S_EMIT : S_IDLE;
               end
            end
            S_EMIT: begin
               if (cmd.emit) begin
                  if (idx_ff == st.n_out_m1) state_ff <= S_IDLE;
                  else                       idx_ff   <= idx_ff + 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // Checks
   a_act_updates: assert property (@(posedge clock) disable iff (reset)
      cmd.take && st.is_act |=> cmd.update)
      else $error("activation not followed by window update");

   a_update_starts: assert property (@(posedge clock) disable iff (reset)
      cmd.update |=> cmd.issue && (cmd.idx == '0))
      else $error("MAC issue did not start at channel zero");

   a_issue_range: assert property (@(posedge clock) disable iff (reset)
      cmd.issue |-> cmd.idx <= st.n_out_m1)
      else $error("MAC issue beyond output channel count");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && cmd.emit_last |=> !cmd.emit)
      else $error("emission continued after last channel");

endmodule

`default_nettype wire
